// ===== rtl/rhcw_pkg.sv =====
`default_nettype none
package rhcw_pkg;

    localparam int CH_W        = 8;
    localparam int HNUM_W      = 17;   // hue numerator, up to 360 * 255
    localparam int SNUM_W      = 16;   // saturation numerator, 255 * d
    localparam int DEG_W       = 9;    // hue in degrees, 0..360
    localparam int DIV_STAGES  = (DEG_W + 1) / 2;
    localparam int RECIP_SHIFT = 22;
    localparam int K_W         = 22;
    localparam int PROD_W      = 30;
    localparam int CFG_IDX_W   = 3;

    // floor(x / 180) == (x * ceil(2^22 / 180)) >> 22 for x up to 180 * 128,
    // with the 127 or 128 scale folded into the constant
    localparam logic [K_W-1:0]   K_LOW    = 22'd2959354;   // 127 * 23302
    localparam logic [K_W-1:0]   K_HIGH   = 22'd2982656;   // 128 * 23302
    localparam logic [DEG_W-1:0] DEG_HALF = 9'd180;
    localparam logic [DEG_W-1:0] DEG_FULL = 9'd360;

    typedef enum logic [1:0] {
        SEC_RED_GB,
        SEC_GREEN,
        SEC_RED_BG,
        SEC_BLUE
    } sector_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_LOW    = 3'd0,
        CFG_HUE_HIGH   = 3'd1,
        CFG_SAT_LOW    = 3'd2,
        CFG_SAT_HIGH   = 3'd3,
        CFG_INTEN_LOW  = 3'd4,
        CFG_INTEN_HIGH = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CH_W-1:0] hue_low;
        logic signed [CH_W-1:0] hue_high;
        logic [CH_W-1:0]        sat_low;
        logic [CH_W-1:0]        sat_high;
        logic [CH_W-1:0]        inten_low;
        logic [CH_W-1:0]        inten_high;
    } cfg_t;

    typedef struct packed {
        logic              gray;
        logic [CH_W-1:0]   mx;
        logic [CH_W-1:0]   d;
        logic [HNUM_W-1:0] hnum;
        logic [SNUM_W-1:0] snum;
    } num_t;

    typedef struct packed {
        logic              gray;
        logic [CH_W-1:0]   mx;
        logic [CH_W-1:0]   d;
        logic [HNUM_W-1:0] hrem;
        logic [DEG_W-1:0]  hq;
        logic [SNUM_W-1:0] srem;
        logic [CH_W-1:0]   sq;
    } div_work_t;

    typedef struct packed {
        logic             gray;
        logic [CH_W-1:0]  mx;
        logic [DEG_W-1:0] deg;
        logic [CH_W-1:0]  sat;
    } quot_t;

endpackage
`default_nettype wire

// ===== rtl/rhcw_pixel_if.sv =====
`default_nettype none
interface rhcw_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// ===== rtl/rhcw_result_if.sv =====
`default_nettype none
interface rhcw_result_if;
    logic              valid;
    logic              ready;
    logic              accept;
    logic signed [7:0] hue_code;
    logic [7:0]        saturation;
    logic [7:0]        intensity;

    modport source (output valid, output accept, output hue_code, output saturation,
                    output intensity, input ready);
    modport sink   (input valid, input accept, input hue_code, input saturation,
                    input intensity, output ready);
endinterface
`default_nettype wire

// ===== rtl/rhcw_front.sv =====
`default_nettype none
module rhcw_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    rhcw_pixel_if.sink        pixel,
    output logic              num_valid,
    input  wire logic         num_ready,
    output rhcw_pkg::num_t    num_data
);
    import rhcw_pkg::*;

    // stage A: max, min, sector and offset term
    logic                  a_valid_reg;
    logic [CH_W-1:0]       a_mx_reg, a_mx_next;
    logic [CH_W-1:0]       a_d_reg, a_d_next;
    sector_t               a_sec_reg, a_sec_next;
    logic signed [CH_W:0]  a_ofs_reg, a_ofs_next;
    logic [CH_W-1:0]       a_mn;
    logic                  a_ready;

    // stage B: numerators of both divisions
    logic                  b_valid_reg;
    num_t                  b_data_reg, b_data_next;
    logic                  b_ready;

    logic [HNUM_W-1:0]     base_term;
    logic signed [HNUM_W+1:0] hnum_wide;

    assign b_ready     = !b_valid_reg || num_ready;
    assign a_ready     = !a_valid_reg || b_ready;
    assign pixel.ready = a_ready;

    always_comb
    begin
        a_mx_next = pixel.red;
        a_mn      = pixel.red;
        if (pixel.green > a_mx_next)
        begin
            a_mx_next = pixel.green;
        end
        if (pixel.blue > a_mx_next)
        begin
            a_mx_next = pixel.blue;
        end
        if (pixel.green < a_mn)
        begin
            a_mn = pixel.green;
        end
        if (pixel.blue < a_mn)
        begin
            a_mn = pixel.blue;
        end
        a_d_next = a_mx_next - a_mn;

        if (pixel.green > pixel.blue)
        begin
            if (pixel.red > pixel.green)
            begin
                a_sec_next = SEC_RED_GB;
                a_ofs_next = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
            end
            else
            begin
                a_sec_next = SEC_GREEN;
                a_ofs_next = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
            end
        end
        else
        begin
            if (pixel.red > pixel.blue)
            begin
                a_sec_next = SEC_RED_BG;
                a_ofs_next = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
            end
            else
            begin
                a_sec_next = SEC_BLUE;
                a_ofs_next = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
            end
        end
    end

    always_comb
    begin
        case (a_sec_reg)
            SEC_RED_GB: base_term = '0;
            SEC_GREEN:  base_term = {{(HNUM_W-CH_W){1'b0}}, a_d_reg} * HNUM_W'(120);
            SEC_RED_BG: base_term = {{(HNUM_W-CH_W){1'b0}}, a_d_reg} * HNUM_W'(360);
            SEC_BLUE:   base_term = {{(HNUM_W-CH_W){1'b0}}, a_d_reg} * HNUM_W'(240);
            default:    base_term = '0;
        endcase
        hnum_wide = $signed({2'b00, base_term})
                  + {{(HNUM_W+1-CH_W){a_ofs_reg[CH_W]}}, a_ofs_reg} * (HNUM_W+2)'(60);

        b_data_next.gray = (a_d_reg == '0);
        b_data_next.mx   = a_mx_reg;
        b_data_next.d    = a_d_reg;
        b_data_next.hnum = hnum_wide[HNUM_W-1:0];
        b_data_next.snum = {a_d_reg, {CH_W{1'b0}}} - {{CH_W{1'b0}}, a_d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= pixel.valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && pixel.valid)
        begin
            a_mx_reg  <= a_mx_next;
            a_d_reg   <= a_d_next;
            a_sec_reg <= a_sec_next;
            a_ofs_reg <= a_ofs_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign num_valid = b_valid_reg;
    assign num_data  = b_data_reg;

endmodule
`default_nettype wire

// ===== rtl/rhcw_div.sv =====
`default_nettype none
module rhcw_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             num_valid,
    output logic                  num_ready,
    input  wire rhcw_pkg::num_t   num_data,
    output logic                  quot_valid,
    input  wire logic             quot_ready,
    output rhcw_pkg::quot_t       quot_data
);
    import rhcw_pkg::*;

    // one restoring step for the hue quotient, and for saturation where the bit exists
    function automatic div_work_t div_step(input div_work_t w, input logic [3:0] pos);
        logic [HNUM_W-1:0] htry;
        logic [SNUM_W-1:0] stry;
        div_work_t         r;
        r    = w;
        htry = {{(HNUM_W-CH_W){1'b0}}, w.d} << pos;
        stry = {{(SNUM_W-CH_W){1'b0}}, w.mx} << pos;
        if (w.hrem >= htry)
        begin
            r.hrem    = w.hrem - htry;
            r.hq[pos] = 1'b1;
        end
        if ((pos < 4'(CH_W)) && (w.srem >= stry))
        begin
            r.srem         = w.srem - stry;
            r.sq[pos[2:0]] = 1'b1;
        end
        return r;
    endfunction

    logic      v_reg  [DIV_STAGES];
    div_work_t w_reg  [DIV_STAGES];
    div_work_t w_next [DIV_STAGES];
    logic      rdy    [DIV_STAGES];
    logic      v_in   [DIV_STAGES];
    div_work_t w_in   [DIV_STAGES];

    assign v_in[0]      = num_valid;
    assign w_in[0].gray = num_data.gray;
    assign w_in[0].mx   = num_data.mx;
    assign w_in[0].d    = num_data.d;
    assign w_in[0].hrem = num_data.hnum;
    assign w_in[0].hq   = '0;
    assign w_in[0].srem = num_data.snum;
    assign w_in[0].sq   = '0;

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            localparam int HI = DEG_W - 1 - 2 * k;
            localparam int LO = DEG_W - 2 - 2 * k;

            if (k > 0)
            begin : g_link
                assign v_in[k] = v_reg[k-1];
                assign w_in[k] = w_reg[k-1];
            end

            if (k < DIV_STAGES - 1)
            begin : g_rdy_mid
                assign rdy[k] = !v_reg[k] || rdy[k+1];
            end
            else
            begin : g_rdy_last
                assign rdy[k] = !v_reg[k] || quot_ready;
            end

            always_comb
            begin
                w_next[k] = div_step(w_in[k], 4'(HI));
                if (LO >= 0)
                begin
                    w_next[k] = div_step(w_next[k], 4'(LO));
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (rdy[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && v_in[k])
                begin
                    w_reg[k] <= w_next[k];
                end
            end
        end
    endgenerate

    assign num_ready       = rdy[0];
    assign quot_valid      = v_reg[DIV_STAGES-1];
    assign quot_data.gray  = w_reg[DIV_STAGES-1].gray;
    assign quot_data.mx    = w_reg[DIV_STAGES-1].mx;
    assign quot_data.deg   = w_reg[DIV_STAGES-1].hq;
    assign quot_data.sat   = w_reg[DIV_STAGES-1].sq;

endmodule
`default_nettype wire

// ===== rtl/rhcw_map.sv =====
`default_nettype none
module rhcw_map (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rhcw_pkg::cfg_t   cfg,
    input  wire logic             quot_valid,
    output logic                  quot_ready,
    input  wire rhcw_pkg::quot_t  quot_data,
    rhcw_result_if.source         result
);
    import rhcw_pkg::*;

    // stage M: scaled hue product
    logic                 m_valid_reg;
    logic [PROD_W-1:0]    m_prod_reg, m_prod_next;
    logic                 m_upper_reg, m_upper_next;
    logic [CH_W-1:0]      m_sat_reg, m_sat_next;
    logic [CH_W-1:0]      m_mx_reg;
    logic                 m_ready;

    logic [DEG_W-1:0]     deg_eff;
    logic [DEG_W-1:0]     span;
    logic [K_W-1:0]       kmul;
    logic [DEG_W+K_W-1:0] prod_full;

    // stage F: output register
    logic                 f_valid_reg;
    logic                 f_accept_reg, f_accept_next;
    logic signed [CH_W-1:0] f_hue_reg, f_hue_next;
    logic [CH_W-1:0]      f_sat_reg, f_inten_reg;
    logic                 f_ready;
    logic [CH_W-1:0]      mag;

    assign f_ready    = !f_valid_reg || result.ready;
    assign m_ready    = !m_valid_reg || f_ready;
    assign quot_ready = m_ready;

    always_comb
    begin
        deg_eff      = quot_data.gray ? '0 : quot_data.deg;
        m_upper_next = (deg_eff > DEG_HALF);
        span         = m_upper_next ? (DEG_FULL - deg_eff) : deg_eff;
        kmul         = m_upper_next ? K_HIGH : K_LOW;
        prod_full    = {{K_W{1'b0}}, span} * {{DEG_W{1'b0}}, kmul};
        m_prod_next  = prod_full[PROD_W-1:0];
        m_sat_next   = quot_data.gray ? '0 : quot_data.sat;
    end

    always_comb
    begin
        mag           = m_prod_reg[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
        f_hue_next    = m_upper_reg ? $signed(CH_W'(0) - mag) : $signed(mag);
        f_accept_next = (f_hue_next >= cfg.hue_low) && (f_hue_next <= cfg.hue_high)
                     && (m_sat_reg >= cfg.sat_low) && (m_sat_reg <= cfg.sat_high)
                     && (m_mx_reg >= cfg.inten_low) && (m_mx_reg <= cfg.inten_high);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
            begin
                m_valid_reg <= quot_valid;
            end
            if (f_ready)
            begin
                f_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_ready && quot_valid)
        begin
            m_prod_reg  <= m_prod_next;
            m_upper_reg <= m_upper_next;
            m_sat_reg   <= m_sat_next;
            m_mx_reg    <= quot_data.mx;
        end
        if (f_ready && m_valid_reg)
        begin
            f_accept_reg <= f_accept_next;
            f_hue_reg    <= f_hue_next;
            f_sat_reg    <= m_sat_reg;
            f_inten_reg  <= m_mx_reg;
        end
    end

    assign result.valid      = f_valid_reg;
    assign result.accept     = f_accept_reg;
    assign result.hue_code   = f_hue_reg;
    assign result.saturation = f_sat_reg;
    assign result.intensity  = f_inten_reg;

endmodule
`default_nettype wire

// ===== rtl/rgb_to_hsi_color_window_core.sv =====
// RGB to hue/saturation/intensity color window.
// Pixels enter on the pixel channel (valid/ready, red/green/blue, 8 bits each).
// Each pixel gives one item on the result channel: intensity (largest channel),
// saturation floor(255*(max-min)/max), a signed hue code (0..127 for 0..180
// degrees, zero or negative above) and an accept flag that is high when all
// three lie inside the configured inclusive windows.
// Windows are set through cfg_we / cfg_index / cfg_data (indexes 0..5: hue low,
// hue high, saturation low, saturation high, intensity low, intensity high);
// write them while no item is in flight. Other indexes are dropped.
// Nine register stages: 2 front stages, 5 divider stages (two hue quotient bits
// each but one in the last) and 2 mapping stages. The first stage loads on the
// accepting edge, and the result is held in the last mapping stage's register.
// Throughput is one item per cycle while the result channel is ready; each stage
// advances whenever the stage ahead has room, so bubbles collapse and the pixel
// channel keeps accepting until all nine stages hold an item.
// When the receiver stalls, results hold in the output register and the stages
// behind it fill up before ready drops. Reset empties the pipe and clears all
// window registers to zero.
`default_nettype none
module rgb_to_hsi_color_window_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    rhcw_pixel_if.sink                            pixel,
    rhcw_result_if.source                         result,
    input  wire logic                             cfg_we,
    input  wire logic [rhcw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rhcw_pkg::CH_W-1:0]        cfg_data
);
    import rhcw_pkg::*;

    cfg_t  cfg_reg;

    logic  num_valid;
    logic  num_ready;
    num_t  num_data;

    logic  quot_valid;
    logic  quot_ready;
    quot_t quot_data;

    // Window registers: write by index, ignore unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HUE_LOW:    cfg_reg.hue_low    <= $signed(cfg_data);
                CFG_HUE_HIGH:   cfg_reg.hue_high   <= $signed(cfg_data);
                CFG_SAT_LOW:    cfg_reg.sat_low    <= cfg_data;
                CFG_SAT_HIGH:   cfg_reg.sat_high   <= cfg_data;
                CFG_INTEN_LOW:  cfg_reg.inten_low  <= cfg_data;
                CFG_INTEN_HIGH: cfg_reg.inten_high <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Front: max/min, sector and the two division numerators.
    rhcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num_data  (num_data)
    );

    // Divider: hue degrees and saturation, up to two quotient bits of each per stage.
    rhcw_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .num_valid  (num_valid),
        .num_ready  (num_ready),
        .num_data   (num_data),
        .quot_valid (quot_valid),
        .quot_ready (quot_ready),
        .quot_data  (quot_data)
    );

    // Map: degrees to hue code, window compare, output register.
    rhcw_map u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .quot_valid (quot_valid),
        .quot_ready (quot_ready),
        .quot_data  (quot_data),
        .result     (result)
    );

endmodule
`default_nettype wire
